// ===== rtl/quad_encoder_period_counter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature encoder period counter
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef QUAD_ENCODER_PERIOD_COUNTER_ASSERT_SVH
`define QUAD_ENCODER_PERIOD_COUNTER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define QEPC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qepc same-cycle check failed");

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define QEPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qepc next-cycle check failed");

`endif

// ===== rtl/qepc_pkg.sv =====
// ----------------------------------------------------------------------------
// qepc_pkg
// Shared constants, types and helpers of the quadrature encoder period counter.
// ----------------------------------------------------------------------------
package qepc_pkg;

    localparam int NUM_WHEELS = 4;   // active lanes, 1..8
    localparam int COUNT_BITS = 32;  // running count width, 8..64
    localparam int OUT_WHEELS = 4;   // wheels carried by a result item
    localparam int PHASE_W    = 4;   // width of each phase level field
    localparam int PULSE_W    = 32;  // width of a pulse field
    localparam int HEAD_W     = 2;   // width of a heading field

    localparam int S_FIELD_W  = 2 * PHASE_W;
    localparam int S_TDATA_W  = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W  = OUT_WHEELS * (PULSE_W + HEAD_W);
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;
    localparam int HEAD_BASE  = OUT_WHEELS * PULSE_W;

    typedef logic signed [COUNT_BITS-1:0] count_t;
    typedef logic signed [PULSE_W-1:0]    pulse_t;
    typedef logic signed [HEAD_W-1:0]     heading_t;

    localparam count_t COUNT_TOP    = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam count_t COUNT_BOTTOM = {1'b1, {(COUNT_BITS-1){1'b0}}};

    localparam heading_t HEAD_FWD  = 2'sb01;
    localparam heading_t HEAD_REV  = 2'sb11;
    localparam heading_t HEAD_STOP = 2'sb00;

    // Control and phase levels handed to one lane for one item.
    typedef struct packed {
        logic accept;
        logic period_end;
        logic phase_a;
        logic phase_b;
    } lane_in_t;

    // Low pulse bits of a count, sign-extended first where the count is narrow.
    function automatic pulse_t to_pulse(count_t c);
        logic signed [63:0] wide;
        wide = 64'(c);
        return wide[PULSE_W-1:0];
    endfunction

    function automatic heading_t sign_of(count_t c);
        heading_t h;
        if (c[COUNT_BITS-1]) begin
            h = HEAD_REV;
        end else if (c == '0) begin
            h = HEAD_STOP;
        end else begin
            h = HEAD_FWD;
        end
        return h;
    endfunction

endpackage

// ===== rtl/qepc_lane.sv =====
// ----------------------------------------------------------------------------
// qepc_lane
// One wheel: A-edge detection, saturating up/down count, clear on period end.
// ----------------------------------------------------------------------------
module qepc_lane (
    input  logic              aclk,
    input  logic              aresetn,
    input  qepc_pkg::lane_in_t lane_in,
    output qepc_pkg::count_t  count_stepped
);
    import qepc_pkg::*;

    logic   prior_a_reg;
    logic   prior_a_next;
    count_t count_reg;
    count_t count_next;
    logic   rise;

    assign rise = lane_in.phase_a & ~prior_a_reg;

    // B equal to A on a rising A steps down, otherwise up; hold at the bounds.
    always_comb begin
        count_stepped = count_reg;
        if (rise) begin
            if (lane_in.phase_b == lane_in.phase_a) begin
                if (count_reg != COUNT_BOTTOM) begin
                    count_stepped = count_reg - count_t'(1);
                end
            end else begin
                if (count_reg != COUNT_TOP) begin
                    count_stepped = count_reg + count_t'(1);
                end
            end
        end
    end

    always_comb begin
        prior_a_next = prior_a_reg;
        count_next   = count_reg;
        if (lane_in.accept) begin
            prior_a_next = lane_in.phase_a;
            count_next   = lane_in.period_end ? count_t'(0) : count_stepped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_a_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            prior_a_reg <= prior_a_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ===== rtl/qepc_merge.sv =====
// ----------------------------------------------------------------------------
// qepc_merge
// Latch lane counts on period end, derive headings, hold the result item.
// ----------------------------------------------------------------------------
module qepc_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic                              period_end,
    input  qepc_pkg::count_t                  lane_count [qepc_pkg::NUM_WHEELS],
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [qepc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import qepc_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [M_FIELD_W-1:0] fields;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    for (genvar i = 0; i < OUT_WHEELS; i++) begin : g_wheel
        if (i < NUM_WHEELS) begin : g_live
            pulse_t   pulse_reg;
            pulse_t   pulse_next;
            heading_t heading_reg;
            heading_t heading_next;

            always_comb begin
                pulse_next   = pulse_reg;
                heading_next = heading_reg;
                if (accept && period_end) begin
                    pulse_next   = to_pulse(lane_count[i]);
                    heading_next = sign_of(lane_count[i]);
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    pulse_reg   <= '0;
                    heading_reg <= HEAD_STOP;
                end else begin
                    pulse_reg   <= pulse_next;
                    heading_reg <= heading_next;
                end
            end

            assign fields[i*PULSE_W +: PULSE_W]             = pulse_reg;
            assign fields[HEAD_BASE + i*HEAD_W +: HEAD_W]   = heading_reg;
        end else begin : g_idle
            assign fields[i*PULSE_W +: PULSE_W]             = '0;
            assign fields[HEAD_BASE + i*HEAD_W +: HEAD_W]   = HEAD_STOP;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_TDATA_W'(fields);

endmodule

// ===== rtl/quad_encoder_period_counter.sv =====
// ----------------------------------------------------------------------------
// quad_encoder_period_counter
// Four-wheel x1 quadrature counter with per-period latched counts and headings.
// ----------------------------------------------------------------------------
// Takes one item per clock: each item carries the sampled A and B levels of
// every wheel and a period-end flag on s_tlast. A rising A level (relative to
// the previous item; A starts low after reset) steps the wheel's running
// count down when B is high and up when B is low, saturating at the signed
// count bounds. When s_tlast is set, the counts after that item's edges are
// latched, each heading becomes the sign of its latch (+1, -1 or 0), and the
// running counts clear. Every item returns one result with the latched
// counts and headings in the cycle after acceptance, from an output register.
// Each wheel has its own lane with a single add/compare, so the rate is one
// item per cycle whenever the result side takes items; while a result waits
// with m_tready low, s_tready drops and the input holds.
// ----------------------------------------------------------------------------
module quad_encoder_period_counter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // phase_a_levels[3:0], phase_b_levels[7:4]
    input  logic [qepc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pulses_wheel0..3 [127:0] (32 bits each, wheel 0 lowest),
    // heading_wheel0..3 [135:128] (2 bits each, wheel 0 lowest)
    output logic [qepc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import qepc_pkg::*;

    logic   s_accept;
    count_t lane_count [NUM_WHEELS];

    // Accept when the output register is empty or its item leaves this cycle.
    assign s_tready = !m_tvalid || m_tready;
    assign s_accept = s_tvalid && s_tready;

    for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_lane
        lane_in_t lane_in;

        // Wheels beyond the phase fields never see an edge.
        if (i < PHASE_W) begin : g_pins
            assign lane_in.phase_a = s_tdata[i];
            assign lane_in.phase_b = s_tdata[PHASE_W + i];
        end else begin : g_nopins
            assign lane_in.phase_a = 1'b0;
            assign lane_in.phase_b = 1'b0;
        end
        assign lane_in.accept     = s_accept;
        assign lane_in.period_end = s_tlast;

        qepc_lane u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .lane_in       (lane_in),
            .count_stepped (lane_count[i])
        );
    end

    qepc_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .period_end (s_tlast),
        .lane_count (lane_count),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

`include "quad_encoder_period_counter_assert.svh"

    // An empty output register never blocks the input.
    `QEPC_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)
    // A stalled result blocks the input.
    `QEPC_ASSERT_SAME(a_block_when_stalled, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    // Every accepted item produces a result in the next cycle.
    `QEPC_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_accept, m_tvalid)

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-wheel quadrature period counter.
// ----------------------------------------------------------------------------
// A queue of phase samples, built up front, feeds a clocked stream driver.
// Every accepted sample runs through a local x1 decoder that tracks the
// previous A levels, the running counts and the latched counts and headings.
// Each decoded report is queued, and the monitor compares every result item
// field by field with the oldest report. Both sides insert random gaps, with
// stretches of back-to-back traffic in between.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_LIMIT   = 2000;   // stalled cycles before giving up
    localparam int TAIL_CYCLES  = 20;     // quiet cycles after the last result
    localparam int RANDOM_ITEMS = 1100;
    localparam int MAX_REPORTS  = 10;     // mismatches printed in full

    // One input item: A levels, B levels, period-end flag.
    typedef struct packed {
        logic [3:0] phase_a;
        logic [3:0] phase_b;
        logic       period_end;
    } wheel_sample_t;

    // One result item, laid out exactly like m_tdata: headings above pulses.
    typedef struct packed {
        qepc_pkg::heading_t [3:0] heads;
        qepc_pkg::pulse_t   [3:0] pulses;
    } wheel_report_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [qepc_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tlast  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [qepc_pkg::M_TDATA_W-1:0] m_tdata;

    wheel_sample_t sample_queue[$];
    wheel_report_t expected_reports[$];

    // Decoder state mirrored from the block.
    logic [3:0]          prev_a;
    qepc_pkg::count_t    run_cnt[4];
    qepc_pkg::count_t    latch_cnt[4];
    qepc_pkg::heading_t  latch_head[4];

    // Handshakes seen at the last rising edge, read by the falling-edge drivers.
    logic s_taken = 1'b0;
    logic m_taken = 1'b0;

    int  mismatches  = 0;
    int  idle_cycles = 0;
    int  s_gap       = 0;
    int  m_stall     = 0;
    bit  s_burst     = 1'b0;
    bit  m_burst     = 1'b1;

    always #HALF_PERIOD aclk = ~aclk;

    quad_encoder_period_counter DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Apply one sample to the decoder and return the report it produces.
    task automatic decode_sample(input wheel_sample_t smp, output wheel_report_t rpt);
        logic [3:0] rise;
        rise = smp.phase_a & ~prev_a;
        for (int w = 0; w < 4; w++) begin
            if (rise[w]) begin
                // B high on a rising A means B equals A: step down, else up.
                if (smp.phase_b[w]) begin
                    if (run_cnt[w] != qepc_pkg::COUNT_BOTTOM) run_cnt[w] = run_cnt[w] - 1;
                end else begin
                    if (run_cnt[w] != qepc_pkg::COUNT_TOP) run_cnt[w] = run_cnt[w] + 1;
                end
            end
        end
        prev_a = smp.phase_a;
        // Period end latches the counts after this item's edges, then clears.
        if (smp.period_end) begin
            for (int w = 0; w < 4; w++) begin
                latch_cnt[w] = run_cnt[w];
                if (run_cnt[w] > 0)
                    latch_head[w] = qepc_pkg::HEAD_FWD;
                else if (run_cnt[w] < 0)
                    latch_head[w] = qepc_pkg::HEAD_REV;
                else
                    latch_head[w] = qepc_pkg::HEAD_STOP;
                run_cnt[w] = '0;
            end
        end
        for (int w = 0; w < 4; w++) begin
            rpt.pulses[w] = latch_cnt[w];
            rpt.heads[w]  = latch_head[w];
        end
    endtask

    task automatic note_mismatch(input string what, input int wheel,
                                 input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s wheel %0d expected %h got %h", what, wheel, want, got);
    endtask

    task automatic push_sample(input logic [3:0] a, input logic [3:0] b, input logic pe);
        wheel_sample_t smp;
        smp.phase_a    = a;
        smp.phase_b    = b;
        smp.period_end = pe;
        sample_queue.push_back(smp);
    endtask

    // Sample the input side into the decoder and check the result side.
    always @(posedge aclk) begin
        wheel_sample_t smp;
        wheel_report_t rpt;
        wheel_report_t got;
        if (!aresetn) begin
            prev_a = '0;
            for (int w = 0; w < 4; w++) begin
                run_cnt[w]    = '0;
                latch_cnt[w]  = '0;
                latch_head[w] = qepc_pkg::HEAD_STOP;
            end
            s_taken     <= 1'b0;
            m_taken     <= 1'b0;
            idle_cycles = 0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            m_taken <= m_tvalid && m_tready;
            // Queue the report first so a same-edge result still finds it.
            if (s_tvalid && s_tready) begin
                smp.phase_a    = s_tdata[3:0];
                smp.phase_b    = s_tdata[7:4];
                smp.period_end = s_tlast;
                decode_sample(smp, rpt);
                expected_reports.push_back(rpt);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_reports.size() == 0) begin
                    note_mismatch("unexpected result", 0, 32'h0, got.pulses[0]);
                end else begin
                    rpt = expected_reports.pop_front();
                    for (int w = 0; w < 4; w++) begin
                        if (got.pulses[w] !== rpt.pulses[w])
                            note_mismatch("pulses", w, rpt.pulses[w], got.pulses[w]);
                        if (got.heads[w] !== rpt.heads[w])
                            note_mismatch("heading", w, 32'(rpt.heads[w]), 32'(got.heads[w]));
                    end
                end
            end
            // Watchdog: count edges where neither side moves an item.
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Input driver: hold an item until taken, then idle for its drawn gap.
    always @(negedge aclk) begin
        wheel_sample_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_taken) begin
            // hold the current item
        end else if (s_gap > 0) begin
            s_tvalid <= 1'b0;
            s_gap--;
        end else if (sample_queue.size() > 0) begin
            nxt = sample_queue.pop_front();
            s_tdata  <= {nxt.phase_b, nxt.phase_a};
            s_tlast  <= nxt.period_end;
            s_tvalid <= 1'b1;
            if ($urandom_range(0, 39) == 0) s_burst = ~s_burst;
            s_gap = s_burst ? 0 : $urandom_range(0, 15);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result side: after every taken result, stall for a drawn number of cycles.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_taken) begin
                if ($urandom_range(0, 39) == 0) m_burst = ~m_burst;
                m_stall = m_burst ? 0 : $urandom_range(0, 15);
            end
            if (m_stall > 0) begin
                m_tready <= 1'b0;
                m_stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int wheel_pos[4];
        int wheel_mode[4];
        int seg_len;
        int step;
        logic [3:0] a;
        logic [3:0] b;

        // First sample after reset: high A counts as an edge on every wheel.
        push_sample(4'hF, 4'h0, 1'b0);
        push_sample(4'h0, 4'hF, 1'b0);
        push_sample(4'hF, 4'hF, 1'b0);     // step every wheel back down
        push_sample(4'hF, 4'hF, 1'b1);     // no edge, latch zero: stopped
        push_sample(4'h0, 4'h0, 1'b0);
        push_sample(4'h5, 4'h0, 1'b0);     // wheels 0 and 2 up
        push_sample(4'h0, 4'hA, 1'b0);
        push_sample(4'hA, 4'hA, 1'b0);     // wheels 1 and 3 down
        push_sample(4'hA, 4'h5, 1'b1);     // latch mixed headings
        push_sample(4'h0, 4'h0, 1'b1);     // empty period
        push_sample(4'hF, 4'hF, 1'b1);     // edge and latch on the same item
        push_sample(4'h0, 4'h0, 1'b0);
        push_sample(4'hF, 4'h0, 1'b1);
        push_sample(4'hF, 4'hF, 1'b1);     // steady high A: no edge
        push_sample(4'h0, 4'h0, 1'b0);
        push_sample(4'h9, 4'h6, 1'b0);
        push_sample(4'h6, 4'h9, 1'b0);
        push_sample(4'hF, 4'h3, 1'b1);

        // Random part: mostly well-formed quadrature walks ending in a period
        // strobe, mixed with bursts of raw noise.
        for (int w = 0; w < 4; w++) wheel_pos[w] = 0;
        while (sample_queue.size() < RANDOM_ITEMS + 18) begin
            if ($urandom_range(0, 7) == 0) begin
                seg_len = $urandom_range(1, 12);
                for (int k = 0; k < seg_len; k++)
                    push_sample(4'($urandom), 4'($urandom), $urandom_range(0, 3) == 0);
            end else begin
                seg_len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 40);
                for (int w = 0; w < 4; w++) wheel_mode[w] = $urandom_range(0, 3);
                for (int k = 0; k < seg_len; k++) begin
                    for (int w = 0; w < 4; w++) begin
                        case (wheel_mode[w])
                            0: step = ($urandom_range(0, 3) != 0) ? 1 : 0;
                            1: step = ($urandom_range(0, 3) != 0) ? -1 : 0;
                            2: step = 0;
                            default: step = $urandom_range(0, 2) - 1;
                        endcase
                        wheel_pos[w] = (wheel_pos[w] + step + 4) % 4;
                        // Gray sequence 00, 10, 11, 01 as (A, B)
                        a[w] = (wheel_pos[w] == 1) || (wheel_pos[w] == 2);
                        b[w] = (wheel_pos[w] == 2) || (wheel_pos[w] == 3);
                    end
                    push_sample(a, b, k == seg_len - 1);
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (sample_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/qepc_pkg.sv
rtl/qepc_lane.sv
rtl/qepc_merge.sv
rtl/quad_encoder_period_counter.sv
tb/sv/tb_top.sv
